// ===== rtl/ocvm_pkg.sv =====
// Shared constants, types and a function for the omni chassis velocity mixer.
package ocvm_pkg;

	localparam int VelWidth    = 16;
	localparam int AngleWidth  = 16;
	localparam int StepWidth   = VelWidth - 1;
	localparam int OutWidth    = VelWidth + 2;
	localparam int CordicSteps = 16;
	localparam int IterWidth   = 4;
	localparam int CsWidth     = 32;
	localparam int InvGain     = 652032874;
	localparam int Sqrt2Q16    = 92682;
	localparam int QueueDepth  = 2;

	localparam logic [0:0] REG_STEP_XY  = 1'b0;
	localparam logic [0:0] REG_STEP_ROT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ITER,
		ST_ROT,
		ST_DONE
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RAMP,
		BK_MIX,
		BK_SCALE,
		BK_OUT
	} back_state_t;

	// Chassis-frame request passed from front to back.
	typedef struct packed {
		logic signed [VelWidth-1:0] vx;
		logic signed [VelWidth-1:0] vy;
		logic signed [VelWidth-1:0] rot;
	} chassis_req_t;

	function automatic logic [31:0] atan_turn(input logic [IterWidth-1:0] i);
		logic [31:0] r;
		case (i)
			4'd0:  r = 32'h20000000;
			4'd1:  r = 32'h12E4051E;
			4'd2:  r = 32'h09FB385B;
			4'd3:  r = 32'h051111D4;
			4'd4:  r = 32'h028B0D43;
			4'd5:  r = 32'h0145D7E1;
			4'd6:  r = 32'h00A2F61E;
			4'd7:  r = 32'h00517C55;
			4'd8:  r = 32'h0028BE53;
			4'd9:  r = 32'h00145F2F;
			4'd10: r = 32'h000A2F98;
			4'd11: r = 32'h000517CC;
			4'd12: r = 32'h00028BE6;
			4'd13: r = 32'h000145F3;
			4'd14: r = 32'h0000A2FA;
			default: r = 32'h0000517D;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/ocvm_front.sv =====
// Front: CORDIC sin/cos of the yaw and frame rotation of the velocity request.
module ocvm_front import ocvm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [4*VelWidth-1:0]       s_tdata,
	output logic                        req_valid,
	input  logic                        req_ready,
	output chassis_req_t                req
);

	localparam int ProdWidth = CsWidth + VelWidth + 1;

	front_state_t state_q, state_d;
	logic [IterWidth-1:0] iter_q;
	logic signed [CsWidth-1:0] x_q, y_q;
	logic [31:0] z_q;
	logic flip_q;
	logic signed [VelWidth-1:0] gx_q, gy_q, rot_q;
	logic signed [ProdWidth-1:0] px_q, py_q;
	chassis_req_t req_q;

	logic [31:0] z_in;
	logic [1:0]  quad;
	logic signed [CsWidth-1:0] dx, dy;
	logic signed [ProdWidth-1:0] sumx, sumy;
	logic signed [CsWidth+VelWidth-30:0] shx, shy;
	logic signed [VelWidth-1:0] vx_sat, vy_sat;
	logic take;
	logic signed [ProdWidth-1:0] pxa, pya;
	logic signed [CsWidth-1:0] xn, yn;
	logic signed [CsWidth-1:0] cn, sn;

	localparam logic signed [CsWidth+VelWidth-30:0] VMax = (1 <<< (VelWidth-1)) - 1;
	localparam logic signed [CsWidth+VelWidth-30:0] VMin = -(1 <<< (VelWidth-1));

	assign z_in = {s_tdata[3*VelWidth-1 -: AngleWidth], {(32-AngleWidth){1'b0}}};
	assign quad = z_in[31:30];
	assign take = s_tvalid && s_tready;
	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;

	assign sumx = px_q + ProdWidth'(64'sd1 <<< 29);
	assign sumy = py_q + ProdWidth'(64'sd1 <<< 29);
	assign shx = sumx[ProdWidth-1:30];
	assign shy = sumy[ProdWidth-1:30];
	assign vx_sat = (shx > VMax) ? VMax[VelWidth-1:0] :
		(shx < VMin) ? VMin[VelWidth-1:0] : shx[VelWidth-1:0];
	assign vy_sat = (shy > VMax) ? VMax[VelWidth-1:0] :
		(shy < VMin) ? VMin[VelWidth-1:0] : shy[VelWidth-1:0];

	// rotation products from the last CORDIC step, registered on the entry to ST_ROT
	assign xn = !z_q[31] ? x_q - dx : x_q + dx;
	assign yn = !z_q[31] ? y_q + dy : y_q - dy;
	assign cn = flip_q ? -xn : xn;
	assign sn = flip_q ? -yn : yn;
	assign pxa = ProdWidth'(cn) * ProdWidth'(gx_q) - ProdWidth'(sn) * ProdWidth'(gy_q);
	assign pya = ProdWidth'(sn) * ProdWidth'(gx_q) + ProdWidth'(cn) * ProdWidth'(gy_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_ITER;
			ST_ITER: if (iter_q == IterWidth'(CordicSteps-1)) state_d = ST_ROT;
			ST_ROT:  state_d = ST_DONE;
			ST_DONE: if (req_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		req_valid = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (take) iter_q <= '0;
			else if (state_q == ST_ITER) iter_q <= iter_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			gx_q   <= s_tdata[VelWidth-1:0];
			gy_q   <= s_tdata[2*VelWidth-1:VelWidth];
			rot_q  <= s_tdata[4*VelWidth-1:3*VelWidth];
			flip_q <= (quad == 2'd1) || (quad == 2'd2);
			z_q    <= ((quad == 2'd1) || (quad == 2'd2)) ? z_in + 32'h80000000 : z_in;
			x_q    <= CsWidth'(InvGain);
			y_q    <= '0;
		end else if (state_q == ST_ITER) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_turn(iter_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_turn(iter_q);
			end
		end
		if (state_q == ST_ITER && iter_q == IterWidth'(CordicSteps-1)) begin
			px_q <= pxa;
			py_q <= pya;
		end
		if (state_q == ST_ROT) begin
			req_q.vx  <= vx_sat;
			req_q.vy  <= vy_sat;
			req_q.rot <= rot_q;
		end
	end

	assign req = req_q;

endmodule

// ===== rtl/ocvm_queue.sv =====
// Short request queue between front and back.
module ocvm_queue import ocvm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  chassis_req_t in_req,
	output logic         out_valid,
	input  logic         out_ready,
	output chassis_req_t out_req
);

	chassis_req_t mem_q [QueueDepth];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;

	assign in_ready  = (cnt_q != 2'(QueueDepth));
	assign out_valid = (cnt_q != 2'd0);
	assign out_req   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) wr_q <= wr_q + 1'b1;
			if (out_valid && out_ready) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wr_q] <= in_req;
	end

endmodule

// ===== rtl/ocvm_back.sv =====
// Back: slew limiting against the previous tick and omni-wheel mixing.
module ocvm_back import ocvm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_idx,
	input  logic [StepWidth-1:0]       cfg_data,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  chassis_req_t               req,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [4*OutWidth-1:0]      m_tdata
);

	back_state_t state_q, state_d;
	logic [StepWidth-1:0] step_xy_q, step_rot_q;
	logic signed [VelWidth-1:0] prev_vx_q, prev_vy_q, prev_rot_q;
	chassis_req_t req_q;
	logic signed [VelWidth:0] sum_q, dif_q;
	logic signed [OutWidth-1:0] ssum_q, sdif_q;
	logic signed [OutWidth-1:0] w1, w2, w3, w4;

	function automatic logic signed [VelWidth-1:0] ramp(
		input logic signed [VelWidth-1:0] t,
		input logic signed [VelWidth-1:0] last,
		input logic [StepWidth-1:0] st
	);
		logic signed [VelWidth+1:0] hi, lo, tt;
		hi = (VelWidth+2)'(last) + (VelWidth+2)'($signed({1'b0, st}));
		lo = (VelWidth+2)'(last) - (VelWidth+2)'($signed({1'b0, st}));
		tt = (VelWidth+2)'(t);
		if (tt > hi) tt = hi;
		else if (tt < lo) tt = lo;
		return tt[VelWidth-1:0];
	endfunction

	logic signed [VelWidth+18:0] ps, pd;
	assign ps = (VelWidth+19)'(sum_q) * (VelWidth+19)'(Sqrt2Q16) + (VelWidth+19)'(32768);
	assign pd = (VelWidth+19)'(dif_q) * (VelWidth+19)'(Sqrt2Q16) + (VelWidth+19)'(32768);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (req_valid) state_d = BK_RAMP;
			BK_RAMP:  state_d = BK_MIX;
			BK_MIX:   state_d = BK_SCALE;
			BK_SCALE: state_d = BK_OUT;
			BK_OUT:   if (m_tready) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == BK_IDLE);
		m_tvalid  = (state_q == BK_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			step_xy_q  <= StepWidth'(256);
			step_rot_q <= StepWidth'(256);
			prev_vx_q  <= '0;
			prev_vy_q  <= '0;
			prev_rot_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_STEP_XY:  step_xy_q  <= cfg_data;
					REG_STEP_ROT: step_rot_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == BK_RAMP) begin
				prev_vx_q  <= ramp(req_q.vx, prev_vx_q, step_xy_q);
				prev_vy_q  <= ramp(req_q.vy, prev_vy_q, step_xy_q);
				prev_rot_q <= ramp(req_q.rot, prev_rot_q, step_rot_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req;
		if (state_q == BK_MIX) begin
			sum_q <= (VelWidth+1)'(prev_vx_q) + (VelWidth+1)'(prev_vy_q);
			dif_q <= (VelWidth+1)'(prev_vx_q) - (VelWidth+1)'(prev_vy_q);
		end
		if (state_q == BK_SCALE) begin
			ssum_q <= ps[OutWidth+15:16];
			sdif_q <= pd[OutWidth+15:16];
		end
	end

	logic signed [OutWidth-1:0] rot_x;
	assign rot_x = OutWidth'(prev_rot_q);
	always_comb begin
		w1 = rot_x - sdif_q;
		w2 = rot_x - ssum_q;
		w3 = sdif_q + rot_x;
		w4 = ssum_q + rot_x;
	end

	assign m_tdata = {w4, w3, w2, w1};

endmodule

// ===== rtl/omni_chassis_velocity_mixer.sv =====
// Omni chassis velocity mixer: CORDIC frame rotation, slew limit, wheel mix.
// The front takes a new request only once the last has passed 16 CORDIC steps, the rotation state and queue hand-off.
// The two-entry queue lets the CORDIC start the next request while a result waits.
// Reset (arst_n low): steps return to 256, previous velocities to zero.
// No clearing pass after reset.
module omni_chassis_velocity_mixer import ocvm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [4*VelWidth-1:0]  s_tdata,  // vel_x_gimbal, vel_y_gimbal, yaw_offset, rot_target
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [4*OutWidth-1:0]  m_tdata,  // wheel_one, wheel_two, wheel_three, wheel_four
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_idx,
	input  logic [StepWidth-1:0]   cfg_data
);

	logic f_valid, f_ready, b_valid, b_ready;
	chassis_req_t f_req, b_req;

	ocvm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.req_valid(f_valid), .req_ready(f_ready), .req(f_req)
	);

	ocvm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_req(f_req),
		.out_valid(b_valid), .out_ready(b_ready), .out_req(b_req)
	);

	ocvm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.req_valid(b_valid), .req_ready(b_ready), .req(b_req),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule
